@@ rtl/core/prfe_pkg.sv @@
// shared types and constants of the parameter request frame encoder
package prfe_pkg;

    localparam int unsigned QUEUE_CAPACITY = 256;
    localparam logic [8:0]  QUEUE_LIMIT    = 9'(QUEUE_CAPACITY);
    localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_PARAM  = 2'd1;
    localparam logic [1:0] OP_NOTSUP = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PAGE_CMD  = 3'd0;
    localparam logic [2:0] REG_SIZE_CMD  = 3'd1;
    localparam logic [2:0] REG_FUNC_CMD  = 3'd2;
    localparam logic [2:0] REG_NS_CODE   = 3'd3;
    localparam logic [2:0] REG_RESP_FUNC = 3'd4;

    typedef struct packed {
        logic [7:0] page_cmd;
        logic [7:0] size_cmd;
        logic [7:0] func_cmd;
        logic [7:0] ns_code;
        logic [7:0] resp_func;
    } t_codes;

    // request from the sequencer to the output stage
    typedef struct packed {
        logic       step;
        logic       flush;
        logic       push;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] fill;
    } t_oreq;

endpackage

@@ rtl/core/prfe_cfg.sv @@
// apb register file holding the command codes
module prfe_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output prfe_pkg::t_codes     o_codes
);
    import prfe_pkg::*;

    t_codes     r_codes;
    logic       wr_en;
    logic [7:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign o_codes = r_codes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_PAGE_CMD:  r_codes.page_cmd  <= pwdata[7:0];
                REG_SIZE_CMD:  r_codes.size_cmd  <= pwdata[7:0];
                REG_FUNC_CMD:  r_codes.func_cmd  <= pwdata[7:0];
                REG_NS_CODE:   r_codes.ns_code   <= pwdata[7:0];
                REG_RESP_FUNC: r_codes.resp_func <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PAGE_CMD:  rd_val = r_codes.page_cmd;
            REG_SIZE_CMD:  rd_val = r_codes.size_cmd;
            REG_FUNC_CMD:  rd_val = r_codes.func_cmd;
            REG_NS_CODE:   rd_val = r_codes.ns_code;
            REG_RESP_FUNC: rd_val = r_codes.resp_func;
            default:       rd_val = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_val};

endmodule

@@ rtl/core/prfe_alu.sv @@
// shared fill adder and capacity compare
module prfe_alu (
    input  logic [7:0] i_fill,
    input  logic [3:0] i_len,
    output logic [8:0] o_sum,
    output logic       o_fits
);
    import prfe_pkg::*;

    assign o_sum  = {1'b0, i_fill} + {5'd0, i_len};
    assign o_fits = o_sum < QUEUE_LIMIT;

endmodule

@@ rtl/core/prfe_seq.sv @@
// phase sequencer: walks the frame slots of one request through the shared adder
module prfe_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_func,
    input  logic [15:0]          i_param,
    input  logic [3:0]           i_size,
    input  logic [63:0]          i_data,
    input  prfe_pkg::t_codes     i_codes,
    input  logic                 i_room,
    output prfe_pkg::t_oreq      o_req
);
    import prfe_pkg::*;

    localparam logic [3:0] PH_FCMD = 4'd0;
    localparam logic [3:0] PH_FUNC = 4'd1;
    localparam logic [3:0] PH_PCMD = 4'd2;
    localparam logic [3:0] PH_PAGE = 4'd3;
    localparam logic [3:0] PH_SCMD = 4'd4;
    localparam logic [3:0] PH_SIZE = 4'd5;
    localparam logic [3:0] PH_NSC  = 4'd6;
    localparam logic [3:0] PH_LOW  = 4'd7;
    localparam logic [3:0] PH_DCHK = 4'd8;
    localparam logic [3:0] PH_DATA = 4'd9;
    localparam logic [3:0] PH_FIN  = 4'd10;

    logic        r_busy;
    logic [3:0]  r_phase;
    logic [2:0]  r_dcnt;
    logic [7:0]  r_held_func;
    logic [7:0]  r_held_page;
    logic [7:0]  r_fill;

    logic        r_ns;
    logic [7:0]  r_func;
    logic [7:0]  r_page;
    logic [7:0]  r_low;
    logic [3:0]  r_size;
    logic [63:0] r_data;

    logic        accept;
    logic        step;
    logic        active;
    logic [7:0]  slot_byte;
    logic [3:0]  len;
    logic [8:0]  sum;
    logic        fits;
    logic        push;
    logic [3:0]  sat_size;

    prfe_alu u_alu (
        .i_fill (r_fill),
        .i_len  (len),
        .o_sum  (sum),
        .o_fits (fits)
    );

    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign step       = r_busy && i_room;
    assign sat_size   = (i_size > MAX_DATA_BYTES) ? MAX_DATA_BYTES : i_size;

    always_comb begin
        active    = 1'b0;
        slot_byte = 8'd0;
        len       = 4'd1;
        unique case (r_phase)
            PH_FCMD: begin
                active    = (r_func != r_held_func) && (r_fill != 8'd0);
                slot_byte = i_codes.func_cmd;
            end
            PH_FUNC: begin
                active    = r_func != r_held_func;
                slot_byte = r_func;
            end
            PH_PCMD: begin
                active    = r_page != r_held_page;
                slot_byte = i_codes.page_cmd;
            end
            PH_PAGE: begin
                active    = r_page != r_held_page;
                slot_byte = r_page;
            end
            PH_SCMD: begin
                active    = r_size > 4'd1;
                slot_byte = i_codes.size_cmd;
            end
            PH_SIZE: begin
                active    = r_size > 4'd1;
                slot_byte = {4'd0, r_size};
            end
            PH_NSC: begin
                active    = r_ns;
                slot_byte = i_codes.ns_code;
            end
            PH_LOW: begin
                active    = 1'b1;
                slot_byte = r_low;
            end
            // whole data block is checked against capacity once
            PH_DCHK: begin
                len = r_size;
            end
            PH_DATA: begin
                active    = 1'b1;
                slot_byte = r_data[7:0];
            end
            default: ;
        endcase
    end

    assign push = step && active && (fits || (r_phase == PH_DATA));

    always_comb begin
        o_req.step  = step;
        o_req.flush = step && (r_phase == PH_FIN);
        o_req.push  = push;
        o_req.data  = slot_byte;
        o_req.index = r_fill;
        o_req.fill  = (r_phase == PH_FIN) ? r_fill : sum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_FIN;
            r_dcnt      <= 3'd0;
            r_held_func <= 8'd0;
            r_held_page <= 8'd0;
            r_fill      <= 8'd0;
        end else if (accept) begin
            r_busy <= 1'b1;
            if (i_op == OP_CLEAR) begin
                r_held_func <= 8'd0;
                r_held_page <= 8'd0;
                r_fill      <= 8'd0;
                r_phase     <= PH_FIN;
            end else if (i_op == OP_PARAM || i_op == OP_NOTSUP) begin
                r_phase <= PH_FCMD;
            end else begin
                r_phase <= PH_FIN;
            end
        end else if (step) begin
            if (push) begin
                r_fill <= sum[7:0];
            end
            unique case (r_phase)
                PH_FUNC: begin
                    if (active) begin
                        r_held_func <= r_func;
                    end
                    r_phase <= PH_PCMD;
                end
                PH_PAGE: begin
                    if (active) begin
                        r_held_page <= r_page;
                    end
                    r_phase <= PH_SCMD;
                end
                PH_DCHK: begin
                    r_dcnt <= 3'd0;
                    if ((r_size != 4'd0) && fits) begin
                        r_phase <= PH_DATA;
                    end else begin
                        r_phase <= PH_FIN;
                    end
                end
                PH_DATA: begin
                    r_dcnt <= r_dcnt + 3'd1;
                    if ({1'b0, r_dcnt} == r_size - 4'd1) begin
                        r_phase <= PH_FIN;
                    end
                end
                PH_FIN: begin
                    r_busy <= 1'b0;
                end
                default: begin
                    r_phase <= r_phase + 4'd1;
                end
            endcase
        end
    end

    // request payload, latched at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ns   <= i_op == OP_NOTSUP;
            r_func <= (i_op == OP_NOTSUP) ? i_codes.resp_func : i_func;
            r_size <= (i_op == OP_NOTSUP) ? 4'd0 : sat_size;
            r_page <= i_param[15:8];
            r_low  <= i_param[7:0];
            r_data <= i_data;
        end else if (step && (r_phase == PH_DATA)) begin
            r_data <= r_data >> 8;
        end
    end

endmodule

@@ rtl/core/prfe_out.sv @@
// one-beat hold for the last flag, then the output register
module prfe_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prfe_pkg::t_oreq      i_req,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_byte,
    output logic [7:0]           o_index,
    output logic [7:0]           o_fill,
    output logic                 o_byte_valid,
    output logic                 o_last
);
    import prfe_pkg::*;

    logic       r_pv, n_pv;
    logic [7:0] r_p_byte, n_p_byte;
    logic [7:0] r_p_index, n_p_index;
    logic [7:0] r_p_fill, n_p_fill;

    logic       r_ov, n_ov;
    logic [7:0] r_o_byte, n_o_byte;
    logic [7:0] r_o_index, n_o_index;
    logic [7:0] r_o_fill, n_o_fill;
    logic       r_o_bv, n_o_bv;
    logic       r_o_last, n_o_last;

    assign o_room = !r_ov || i_ready;

    always_comb begin
        n_pv      = r_pv;
        n_p_byte  = r_p_byte;
        n_p_index = r_p_index;
        n_p_fill  = r_p_fill;
        n_ov      = r_ov && !i_ready;
        n_o_byte  = r_o_byte;
        n_o_index = r_o_index;
        n_o_fill  = r_o_fill;
        n_o_bv    = r_o_bv;
        n_o_last  = r_o_last;
        if (i_req.flush) begin
            n_ov = 1'b1;
            n_pv = 1'b0;
            n_o_last = 1'b1;
            if (r_pv) begin
                n_o_byte  = r_p_byte;
                n_o_index = r_p_index;
                n_o_fill  = r_p_fill;
                n_o_bv    = 1'b1;
            end else begin
                // nothing appended for this request
                n_o_byte  = 8'd0;
                n_o_index = 8'd0;
                n_o_fill  = i_req.fill;
                n_o_bv    = 1'b0;
            end
        end else if (i_req.push) begin
            if (r_pv) begin
                n_ov      = 1'b1;
                n_o_byte  = r_p_byte;
                n_o_index = r_p_index;
                n_o_fill  = r_p_fill;
                n_o_bv    = 1'b1;
                n_o_last  = 1'b0;
            end
            n_pv      = 1'b1;
            n_p_byte  = i_req.data;
            n_p_index = i_req.index;
            n_p_fill  = i_req.fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= n_pv;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_byte  <= n_p_byte;
        r_p_index <= n_p_index;
        r_p_fill  <= n_p_fill;
        r_o_byte  <= n_o_byte;
        r_o_index <= n_o_index;
        r_o_fill  <= n_o_fill;
        r_o_bv    <= n_o_bv;
        r_o_last  <= n_o_last;
    end

    assign o_valid      = r_ov;
    assign o_byte       = r_o_byte;
    assign o_index      = r_o_index;
    assign o_fill       = r_o_fill;
    assign o_byte_valid = r_o_bv;
    assign o_last       = r_o_last;

endmodule

@@ rtl/core/param_request_frame_encoder_core.sv @@
// top level of the parameter request frame encoder
//
// s_axis carries one request per beat; m_axis carries the appended queue
// bytes, one beat per byte, with tlast on the final beat of each request.
// a request that appends nothing (clear, all bytes dropped, unused op)
// gives one beat with tuser low, tlast high and the current fill count.
// the command codes sit in five apb registers at byte addresses 0 to 16.
//
// a sequencer steps through every frame slot of a request, one slot per
// cycle while m_axis does not stall, through a single fill adder and
// capacity compare. a parameter or not-supported request walks all slots
// and one data slot per byte appended (none when the block is dropped);
// clear and unused ops go straight to the final slot.
// s_axis tready is low while a request is in progress. each byte leaves
// once the next byte or the end of its request is produced, since each
// beat is held until the next one shows whether it is the last.
// a stalled receiver freezes the sequencer; no beat is lost.
// reset clears the codes, the current function and page and the fill count.
module param_request_frame_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], function_number[9:2], parameter_number[25:10],
    // data_size[29:26], data_bytes[93:30], zero pad
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], out_index[15:8], fill_count[23:16]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // byte_valid[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import prfe_pkg::*;

    t_codes     codes;
    t_oreq      req;
    logic       room;
    logic [7:0] out_byte;
    logic [7:0] out_index;
    logic [7:0] out_fill;
    logic       out_bv;

    prfe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_codes (codes)
    );

    prfe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (s_axis_tdata[1:0]),
        .i_func     (s_axis_tdata[9:2]),
        .i_param    (s_axis_tdata[25:10]),
        .i_size     (s_axis_tdata[29:26]),
        .i_data     (s_axis_tdata[93:30]),
        .i_codes    (codes),
        .i_room     (room),
        .o_req      (req)
    );

    prfe_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_room       (room),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (out_byte),
        .o_index      (out_index),
        .o_fill       (out_fill),
        .o_byte_valid (out_bv),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata    = {out_fill, out_index, out_byte};
    assign m_axis_tuser[0] = out_bv;

endmodule

@@ rtl/core/prfe_chk.sv @@
// port-level checks for the frame encoder, bound to the top level
module prfe_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("m_axis beat changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("s_axis ready right after accept");

    // an empty beat always closes its request and carries no byte
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata[15:0] == 16'd0))
        else $error("empty beat without tlast or with data");

    // each written byte advances the fill by one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[23:16] == (m_axis_tdata[15:8] + 8'd1))
        else $error("fill count does not follow index");

endmodule

bind param_request_frame_encoder_core prfe_chk u_prfe_chk (.*);
